[hdl/nlmp_pkg.sv]
`default_nettype none
package nlmp_pkg;

   localparam int ByteW   = 8;
   localparam int ValueW  = 16;
   localparam int StatusW = 3;

   localparam logic [ByteW-1:0] CH_STAR  = 8'h2A;
   localparam logic [ByteW-1:0] CH_COLON = 8'h3A;
   localparam logic [ByteW-1:0] CH_SEMI  = 8'h3B;
   localparam logic [ByteW-1:0] CH_MINUS = 8'h2D;
   localparam logic [ByteW-1:0] CH_PLUS  = 8'h2B;
   localparam logic [ByteW-1:0] CH_ZERO  = 8'h30;
   localparam logic [ByteW-1:0] CH_NINE  = 8'h39;
   localparam logic [ByteW-1:0] CH_CR    = 8'h0D;
   localparam logic [ByteW-1:0] CH_LF    = 8'h0A;
   localparam logic [ByteW-1:0] CH_NUL   = 8'h00;

   localparam logic [StatusW-1:0] STATUS_TERM      = 3'd0;
   localparam logic [StatusW-1:0] STATUS_LENGTH    = 3'd1;
   localparam logic [StatusW-1:0] STATUS_NUMBERS   = 3'd2;
   localparam logic [StatusW-1:0] STATUS_INVALID   = 3'd3;
   localparam logic [StatusW-1:0] STATUS_BAD_START = 3'd4;

   localparam int CsrIdxW = 8;
   localparam logic [CsrIdxW-1:0] CSR_LENGTH_LIMIT = 8'd0;
   localparam logic [CsrIdxW-1:0] CSR_NUMBER_LIMIT = 8'd1;

   localparam logic [ByteW-1:0] LENGTH_LIMIT_RST = 8'd64;
   localparam logic [ByteW-1:0] NUMBER_LIMIT_RST = 8'd8;

   typedef struct packed {
      logic             first;
      logic [ByteW-1:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic                     number_valid;
      logic signed [ValueW-1:0] number_value;
      logic [ByteW-1:0]         number_index;
      logic                     done_res;
      logic [StatusW-1:0]       status;
      logic [ByteW-1:0]         number_count;
   } rsp_type;

   typedef struct packed {
      logic              active;
      logic [ByteW-1:0]  position;
      logic [ValueW-1:0] accumulator;
      logic              negative;
      logic [ByteW-1:0]  count;
   } state_type;

endpackage
`default_nettype wire

[hdl/nlmp_step.sv]
`default_nettype none
module nlmp_step (
   input  nlmp_pkg::state_type st,
   input  nlmp_pkg::req_type   req,
   input  logic [7:0]          length_limit,
   input  logic [7:0]          number_limit,
   output nlmp_pkg::state_type st_next,
   output nlmp_pkg::rsp_type   rsp,
   output logic                rsp_emit
);
   import nlmp_pkg::*;

   typedef enum logic [2:0] {
      END_NONE,
      END_SEP,
      END_TERM,
      END_LENGTH,
      END_NUMBERS,
      END_INVALID
   } end_type;

   end_type           code;
   logic [ByteW:0]    new_pos;
   logic [3:0]        digit;
   logic [ValueW-1:0] acc_times_ten;
   logic [ByteW-1:0]  count_next;

   assign digit         = 4'(req.rx_byte - CH_ZERO);
   assign acc_times_ten = {st.accumulator[ValueW-4:0], 3'b000}
                        + {st.accumulator[ValueW-2:0], 1'b0}
                        + {12'd0, digit};
   assign new_pos       = {1'b0, st.position} + 9'd1;

   always_comb begin
      st_next    = st;
      rsp        = '0;
      rsp_emit   = 1'b0;
      code       = END_NONE;
      count_next = st.count;
      if (req.first) begin
         st_next = '0;
         if (req.rx_byte == CH_STAR) begin
            st_next.active   = 1'b1;
            st_next.position = 8'd1;
         end else begin
            rsp_emit     = 1'b1;
            rsp.done_res = 1'b1;
            rsp.status   = STATUS_BAD_START;
         end
      end else if (st.active) begin
         if (req.rx_byte == CH_MINUS) begin
            st_next.negative = 1'b1;
         end else if (req.rx_byte == CH_PLUS) begin
            st_next.negative = st.negative;
         end else if (req.rx_byte inside {[CH_ZERO:CH_NINE]}) begin
            st_next.accumulator = acc_times_ten;
         end else if (req.rx_byte inside {CH_SEMI, CH_CR, CH_LF, CH_NUL}) begin
            code = END_TERM;
         end else if (req.rx_byte == CH_COLON) begin
            code = END_SEP;
         end else begin
            code = END_INVALID;
         end

         if (new_pos >= {1'b0, length_limit}) begin
            code = END_LENGTH;
         end
         st_next.position = new_pos[ByteW-1:0];

         if (code != END_NONE) begin
            rsp_emit = 1'b1;
            if (code == END_SEP || code == END_TERM) begin
               rsp.number_valid = 1'b1;
               rsp.number_value = st.negative ? $signed(16'(-st.accumulator))
                                              : $signed(st.accumulator);
               rsp.number_index = st.count;
               if (st.count != 8'hFF) begin
                  count_next = st.count + 8'd1;
               end
            end
            if (count_next >= number_limit) begin
               code = END_NUMBERS;
            end
            st_next.count       = count_next;
            st_next.accumulator = '0;
            st_next.negative    = 1'b0;
            if (code != END_SEP) begin
               st_next.active = 1'b0;
               rsp.done_res   = 1'b1;
               case (code)
                  END_TERM:    rsp.status = STATUS_TERM;
                  END_LENGTH:  rsp.status = STATUS_LENGTH;
                  END_NUMBERS: rsp.status = STATUS_NUMBERS;
                  default:     rsp.status = STATUS_INVALID;
               endcase
            end
         end
      end
      rsp.number_count = st_next.count;
   end

endmodule
`default_nettype wire

[hdl/number_list_message_parser_core.sv]
// Channel   Ports                               Direction  Payload
// request   req_valid/req_ready/req_payload     in         first, rx_byte
// response  rsp_valid/rsp_ready/rsp_payload     out        number, index, done, status, count
// csr       csr_we/csr_index/csr_wdata          in         length limit, number limit
//
// One byte a cycle: the parse step sits between the parser state registers
// and the response register, so the next byte is taken in the following cycle.
// A request is taken whenever the response register is empty or being drained.
// A response held by rsp_ready low stalls requests until it is taken.
// Synchronous reset: no message open, limits back to 64 and 8.
`default_nettype none
module number_list_message_parser_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  nlmp_pkg::req_type   req_payload,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output nlmp_pkg::rsp_type   rsp_payload,
   input  logic                csr_we,
   input  logic [7:0]          csr_index,
   input  logic [7:0]          csr_wdata
);
   import nlmp_pkg::*;

   state_type        state_ff, state_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff;
   logic             rsp_emit;
   logic [ByteW-1:0] length_limit_ff;
   logic [ByteW-1:0] number_limit_ff;
   logic             req_take;

   nlmp_step u_step (
      .st           (state_ff),
      .req          (req_payload),
      .length_limit (length_limit_ff),
      .number_limit (number_limit_ff),
      .st_next      (state_in),
      .rsp          (rsp_in),
      .rsp_emit     (rsp_emit)
   );

   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign req_take    = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
         length_limit_ff <= LENGTH_LIMIT_RST;
         number_limit_ff <= NUMBER_LIMIT_RST;
      end else begin
         if (csr_we && csr_index == CSR_LENGTH_LIMIT) begin
            length_limit_ff <= csr_wdata;
         end
         if (csr_we && csr_index == CSR_NUMBER_LIMIT) begin
            number_limit_ff <= csr_wdata;
         end
         if (req_take) begin
            state_ff     <= state_in;
            rsp_valid_ff <= rsp_emit;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && rsp_emit) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
`default_nettype wire

[hdl/nlmp_checker.sv]
`default_nettype none
module nlmp_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input nlmp_pkg::rsp_type rsp_payload
);
   import nlmp_pkg::*;

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response dropped or changed under stall");

   a_rsp_content: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.number_valid || rsp_payload.done_res)
      else $error("empty response");

   a_status_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.done_res |-> rsp_payload.status == STATUS_TERM)
      else $error("status without done");

   a_count_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.number_valid
         |-> rsp_payload.number_count == rsp_payload.number_index + 8'd1)
      else $error("count does not follow index");

   a_bad_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.done_res && rsp_payload.status == STATUS_BAD_START
         |-> !rsp_payload.number_valid && rsp_payload.number_count == 8'd0)
      else $error("bad start carries a number");

endmodule

bind number_list_message_parser_core nlmp_checker u_nlmp_checker (.*);
`default_nettype wire
